// ===== hw/rtl/cbpw_pkg.sv =====
// shared types, constants and helpers of the cubic b-spline point warp
package cbpw_pkg;

   localparam int CW     = 32;
   localparam int IW     = 12;
   localparam int PW     = 6;
   localparam int WW     = 25;
   localparam int QDEPTH = 2;
   localparam int ADEPTH = 4096;
   localparam int AW     = 12;
   localparam int DW     = 96;

   localparam int DEF_REGIONS = 13;
   localparam int DEF_VPR     = 8;

   localparam logic [2:0] CSR_ORG_X = 3'd0;
   localparam logic [2:0] CSR_ORG_Y = 3'd1;
   localparam logic [2:0] CSR_ORG_Z = 3'd2;
   localparam logic [2:0] CSR_INV_X = 3'd3;
   localparam logic [2:0] CSR_INV_Y = 3'd4;
   localparam logic [2:0] CSR_INV_Z = 3'd5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_XFORM = 1'b1;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   // ceil(2^30 / 6), exact for quotients of values below 2^29
   localparam logic [27:0] DIV6_MUL = 28'd178956971;

   typedef struct packed {
      logic [2:0][CW-1:0] org;
      logic [2:0][CW-1:0] inv;
   } cfg_type;

   typedef struct packed {
      logic                    is_wr;
      logic                    in_grid;
      logic [IW-1:0]           idx;
      logic [2:0][CW-1:0]      val;
      logic [2:0][PW-1:0]      p;
      logic [2:0][3:0][WW-1:0] w;
   } qent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic clear_done;
   } bstat_type;

   // six times a weight in q.48 to the weight in q0.24, rounded half up
   function automatic logic [WW-1:0] div6_w(input logic [51:0] s);
      logic [51:0] t;
      logic [27:0] y;
      logic [55:0] m;
      t = s + 52'd50331648;
      y = t[51:24];
      m = 56'(y) * 56'(DIV6_MUL);
      return m[54:30];
   endfunction

endpackage

// ===== hw/rtl/cbpw_front.sv =====
// front end: takes requests, finds tile, offset and b-spline weights per axis
module cbpw_front #(
   parameter int REGIONS_X = cbpw_pkg::DEF_REGIONS,
   parameter int REGIONS_Y = cbpw_pkg::DEF_REGIONS,
   parameter int REGIONS_Z = cbpw_pkg::DEF_REGIONS,
   parameter int VPR_X     = cbpw_pkg::DEF_VPR,
   parameter int VPR_Y     = cbpw_pkg::DEF_VPR,
   parameter int VPR_Z     = cbpw_pkg::DEF_VPR
) (
   input  logic                clock,
   input  logic                reset,
   input  cbpw_pkg::cfg_type   cfg,
   input  logic                enable,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [207:0]        req_tdata,
   input  logic                req_tuser,
   input  cbpw_pkg::qstat_type q_stat,
   output logic                push,
   output cbpw_pkg::qent_type  push_ent
);
   import cbpw_pkg::*;

   localparam logic [3:0] F_IDLE = 4'd0;
   localparam logic [3:0] F_MUL  = 4'd1;
   localparam logic [3:0] F_DIV  = 4'd2;
   localparam logic [3:0] F_FIX  = 4'd3;
   localparam logic [3:0] F_SQ   = 4'd4;
   localparam logic [3:0] F_CUBE = 4'd5;
   localparam logic [3:0] F_POLY = 4'd6;
   localparam logic [3:0] F_WGT  = 4'd7;
   localparam logic [3:0] F_PUSH = 4'd8;

   localparam logic [31:0] MUL_X = 32'(64'd2147483648 / 64'(VPR_X));
   localparam logic [31:0] MUL_Y = 32'(64'd2147483648 / 64'(VPR_Y));
   localparam logic [31:0] MUL_Z = 32'(64'd2147483648 / 64'(VPR_Z));
   localparam logic [27:0] LIM_X = 28'(REGIONS_X * VPR_X * 65536);
   localparam logic [27:0] LIM_Y = 28'(REGIONS_Y * VPR_Y * 65536);
   localparam logic [27:0] LIM_Z = 28'(REGIONS_Z * VPR_Z * 65536);

   logic [3:0]              st_ff, st_in;
   logic [1:0]              ax_ff, ax_in;
   logic                    wr_ff, wr_in;
   logic                    inside_ff, inside_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [2:0][CW-1:0]      val_ff, val_in;
   logic [2:0][PW-1:0]      p_ff, p_in;
   logic [2:0][3:0][WW-1:0] w_ff, w_in;
   logic [63:0]             prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   logic [27:0]             v_ff, v_in;
   logic [27:0]             est_ff, est_in;
   logic [15:0]             q_ff, q_in;
   logic [16:0]             u_ff, u_in;
   logic [31:0]             t2_ff, t2_in;
   logic [33:0]             u2_ff, u2_in;
   logic [47:0]             t3_ff, t3_in;
   logic [50:0]             u3_ff, u3_in;
   logic [3:0][51:0]        s_ff, s_in;

   logic [CW-1:0] pt_sel, org_sel, inv_sel, mul_sel;
   logic [27:0]   lim_sel;
   logic [6:0]    vpr_sel;
   logic [32:0]   diff;
   logic [31:0]   mag;
   logic [39:0]   v40;
   logic          out_rng;
   logic [27:0]   v28;
   logic [59:0]   est_mul;
   logic [34:0]   ev, rem;
   logic [27:0]   qt;

   always_comb begin
      case (ax_ff)
         AX_X: begin
            pt_sel = val_ff[0]; org_sel = cfg.org[0]; inv_sel = cfg.inv[0];
            mul_sel = MUL_X; lim_sel = LIM_X; vpr_sel = 7'(VPR_X);
         end
         AX_Y: begin
            pt_sel = val_ff[1]; org_sel = cfg.org[1]; inv_sel = cfg.inv[1];
            mul_sel = MUL_Y; lim_sel = LIM_Y; vpr_sel = 7'(VPR_Y);
         end
         default: begin
            pt_sel = val_ff[2]; org_sel = cfg.org[2]; inv_sel = cfg.inv[2];
            mul_sel = MUL_Z; lim_sel = LIM_Z; vpr_sel = 7'(VPR_Z);
         end
      endcase
   end

   always_comb begin
      diff    = {pt_sel[31], pt_sel} - {org_sel[31], org_sel};
      mag     = diff[32] ? 32'(-diff) : diff[31:0];
      v40     = prod_ff[63:24];
      out_rng = neg_ff ? (prod_ff != 64'd0) : (v40 >= 40'(lim_sel));
      v28     = neg_ff ? 28'd0 : v40[27:0];
      est_mul = 60'(v28) * 60'(mul_sel);
      ev      = 35'(est_ff) * 35'(vpr_sel);
      rem     = 35'(v_ff) - ev;
      qt      = (rem >= 35'(vpr_sel)) ? est_ff + 28'd1 : est_ff;
   end

   assign req_tready = enable && (st_ff == F_IDLE);
   assign push       = (st_ff == F_PUSH) && !q_stat.full;

   always_comb begin
      push_ent.is_wr   = wr_ff;
      push_ent.in_grid = inside_ff;
      push_ent.idx     = idx_ff;
      push_ent.val     = val_ff;
      push_ent.p       = p_ff;
      push_ent.w       = w_ff;
   end

   always_comb begin
      st_in = st_ff; ax_in = ax_ff; wr_in = wr_ff; inside_in = inside_ff;
      idx_in = idx_ff; val_in = val_ff; p_in = p_ff; w_in = w_ff;
      prod_in = prod_ff; neg_in = neg_ff; v_in = v_ff; est_in = est_ff;
      q_in = q_ff; u_in = u_ff; t2_in = t2_ff; u2_in = u2_ff;
      t3_in = t3_ff; u3_in = u3_ff; s_in = s_ff;
      case (st_ff)
         F_IDLE: begin
            if (req_tvalid && req_tready) begin
               ax_in     = AX_X;
               inside_in = 1'b1;
               idx_in    = req_tdata[11:0];
               if (req_tuser == OP_WRITE) begin
                  wr_in  = 1'b1;
                  val_in = {req_tdata[107:76], req_tdata[75:44], req_tdata[43:12]};
                  st_in  = F_PUSH;
               end else begin
                  wr_in  = 1'b0;
                  val_in = {req_tdata[203:172], req_tdata[171:140], req_tdata[139:108]};
                  st_in  = F_MUL;
               end
            end
         end
         F_MUL: begin
            prod_in = 64'(mag) * 64'(inv_sel);
            neg_in  = diff[32];
            st_in   = F_DIV;
         end
         F_DIV: begin
            if (out_rng) begin
               inside_in = 1'b0;
               st_in     = F_PUSH;
            end else begin
               v_in   = v28;
               est_in = est_mul[58:31];
               st_in  = F_FIX;
            end
         end
         F_FIX: begin
            p_in[ax_ff] = qt[21:16];
            q_in        = qt[15:0];
            u_in        = 17'd65536 - 17'(qt[15:0]);
            st_in       = F_SQ;
         end
         F_SQ: begin
            t2_in = 32'(q_ff) * 32'(q_ff);
            u2_in = 34'(u_ff) * 34'(u_ff);
            st_in = F_CUBE;
         end
         F_CUBE: begin
            t3_in = 48'(t2_ff) * 48'(q_ff);
            u3_in = 51'(u2_ff) * 51'(u_ff);
            st_in = F_POLY;
         end
         F_POLY: begin
            s_in[0] = 52'(u3_ff);
            s_in[1] = 52'(t3_ff) * 52'd3 + (52'd4 << 48) - ((52'(t2_ff) * 52'd6) << 16);
            s_in[2] = ((52'(t2_ff) * 52'd3) << 16) + ((52'(q_ff) * 52'd3) << 32)
                    + (52'd1 << 48) - 52'(t3_ff) * 52'd3;
            s_in[3] = 52'(t3_ff);
            st_in   = F_WGT;
         end
         F_WGT: begin
            w_in[ax_ff][0] = div6_w(s_ff[0]);
            w_in[ax_ff][1] = div6_w(s_ff[1]);
            w_in[ax_ff][2] = div6_w(s_ff[2]);
            w_in[ax_ff][3] = div6_w(s_ff[3]);
            if (ax_ff == AX_Z) begin
               st_in = F_PUSH;
            end else begin
               ax_in = ax_ff + 2'd1;
               st_in = F_MUL;
            end
         end
         F_PUSH: begin
            if (!q_stat.full) begin
               st_in = F_IDLE;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
         ax_ff <= AX_X;
      end else begin
         st_ff <= st_in;
         ax_ff <= ax_in;
      end
      wr_ff <= wr_in; inside_ff <= inside_in; idx_ff <= idx_in; val_ff <= val_in;
      p_ff <= p_in; w_ff <= w_in; prod_ff <= prod_in; neg_ff <= neg_in;
      v_ff <= v_in; est_ff <= est_in; q_ff <= q_in; u_ff <= u_in;
      t2_ff <= t2_in; u2_ff <= u2_in; t3_ff <= t3_in; u3_ff <= u3_in; s_ff <= s_in;
   end

endmodule

// ===== hw/rtl/cbpw_queue.sv =====
// short queue of classified requests between front and back end
module cbpw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cbpw_pkg::qent_type  push_ent,
   input  logic                pop,
   output cbpw_pkg::qent_type  head,
   output cbpw_pkg::qstat_type stat
);
   import cbpw_pkg::*;

   localparam int PTW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNW = $clog2(QDEPTH + 1);

   qent_type       q_ff [QDEPTH];
   logic [PTW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNW-1:0] cnt_ff, cnt_in;

   function automatic logic [PTW-1:0] nxt(input logic [PTW-1:0] p);
      return (p == PTW'(QDEPTH - 1)) ? '0 : p + PTW'(1);
   endfunction

   assign head       = q_ff[rp_ff];
   assign stat.full  = (cnt_ff == CNW'(QDEPTH));
   assign stat.empty = (cnt_ff == '0);

   always_comb begin
      wp_in  = push ? nxt(wp_ff) : wp_ff;
      rp_in  = pop ? nxt(rp_ff) : rp_ff;
      cnt_in = cnt_ff + CNW'(push) - CNW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= push_ent;
      end
   end

endmodule

// ===== hw/rtl/cbpw_back.sv =====
// back end: coefficient memory, 64-tap weighted sum and response register
module cbpw_back #(
   parameter int REGIONS_X = cbpw_pkg::DEF_REGIONS,
   parameter int REGIONS_Y = cbpw_pkg::DEF_REGIONS
) (
   input  logic                clock,
   input  logic                reset,
   input  cbpw_pkg::qent_type  head,
   input  cbpw_pkg::qstat_type q_stat,
   output logic                pop,
   output cbpw_pkg::bstat_type stat,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [95:0]         rsp_tdata,
   output logic                rsp_tuser
);
   import cbpw_pkg::*;

   localparam logic [2:0] B_CLR   = 3'd0;
   localparam logic [2:0] B_IDLE  = 3'd1;
   localparam logic [2:0] B_TAP   = 3'd2;
   localparam logic [2:0] B_DRAIN = 3'd3;
   localparam logic [2:0] B_FIN   = 3'd4;

   localparam logic [23:0] CX = 24'(REGIONS_X + 3);
   localparam logic [23:0] CY = 24'(REGIONS_Y + 3);

   logic [DW-1:0] mem [ADEPTH];

   logic [2:0]         st_ff, st_in;
   logic [AW-1:0]      clr_ff, clr_in;
   qent_type           ent_ff, ent_in;
   logic [5:0]         t_ff, t_in;
   logic               v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]      a_ff;
   logic [49:0]        wxyr_ff;
   logic [WW-1:0]      wz_ff;
   logic [DW-1:0]      rd_ff;
   logic [50:0]        qlp_ff;
   logic signed [59:0] px_ff, py_ff, pz_ff;
   logic signed [63:0] ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   logic               rv_ff, rv_in;
   logic [DW-1:0]      rd_out_ff, rd_out_in;
   logic               ins_ff, ins_in;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [DW-1:0] mem_wd;
   logic [6:0]    pxi, pyj, pzk;
   logic [23:0]   lin;
   logic [49:0]   wxy_raw;
   logic [25:0]   wxy;
   logic [50:0]   qlr;
   logic [26:0]   ql;
   logic          out_load;

   function automatic logic [31:0] fin(input logic [31:0] pt, input logic signed [63:0] acc,
                                       input logic ins);
      logic signed [63:0] disp, res;
      disp = (acc + 64'sd8388608) >>> 24;
      res  = 64'(signed'(pt)) + disp;
      if (!ins) begin
         return pt;
      end else if (res > 64'sd2147483647) begin
         return 32'h7FFFFFFF;
      end else if (res < -64'sd2147483648) begin
         return 32'h80000000;
      end
      return res[31:0];
   endfunction

   always_comb begin
      pxi     = 7'(ent_ff.p[0]) + 7'(t_ff[1:0]);
      pyj     = 7'(ent_ff.p[1]) + 7'(t_ff[3:2]);
      pzk     = 7'(ent_ff.p[2]) + 7'(t_ff[5:4]);
      lin     = (24'(pzk) * CY + 24'(pyj)) * CX + 24'(pxi);
      wxy_raw = 50'(ent_ff.w[0][t_ff[1:0]]) * 50'(ent_ff.w[1][t_ff[3:2]]);
      wxy     = 26'((wxyr_ff + 50'd8388608) >> 24);
      qlr     = qlp_ff + 51'd8388608;
      ql      = qlr[50:24];
   end

   assign pop      = (st_ff == B_IDLE) && !q_stat.empty;
   assign out_load = (st_ff == B_FIN) && (!rv_ff || rsp_tready);
   assign stat.clear_done = (st_ff != B_CLR);
   assign mem_we   = (st_ff == B_CLR) || (pop && head.is_wr);
   assign mem_wa   = (st_ff == B_CLR) ? clr_ff : head.idx;
   assign mem_wd   = (st_ff == B_CLR) ? '0 : {head.val[2], head.val[1], head.val[0]};

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_out_ff;
   assign rsp_tuser  = ins_ff;

   always_comb begin
      st_in = st_ff; clr_in = clr_ff; ent_in = ent_ff; t_in = t_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      rv_in = rv_ff; rd_out_in = rd_out_ff; ins_in = ins_ff;
      if (v3_ff) begin
         ax_in = ax_ff + 64'(px_ff);
         ay_in = ay_ff + 64'(py_ff);
         az_in = az_ff + 64'(pz_ff);
      end
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      case (st_ff)
         B_CLR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(ADEPTH - 1)) begin
               st_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop && !head.is_wr) begin
               ent_in = head;
               t_in   = '0;
               ax_in  = '0; ay_in = '0; az_in = '0;
               st_in  = head.in_grid ? B_TAP : B_FIN;
            end
         end
         B_TAP: begin
            t_in = t_ff + 6'd1;
            if (t_ff == 6'd63) begin
               st_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               st_in = B_FIN;
            end
         end
         B_FIN: begin
            if (out_load) begin
               rv_in     = 1'b1;
               ins_in    = ent_ff.in_grid;
               rd_out_in = {fin(ent_ff.val[2], az_ff, ent_ff.in_grid),
                            fin(ent_ff.val[1], ay_ff, ent_ff.in_grid),
                            fin(ent_ff.val[0], ax_ff, ent_ff.in_grid)};
               st_in     = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[a_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= B_CLR;
         clr_ff <= '0;
         rv_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         rv_ff  <= rv_in;
         v1_ff  <= (st_ff == B_TAP);
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
      end
      ent_ff    <= ent_in;
      t_ff      <= t_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      az_ff     <= az_in;
      rd_out_ff <= rd_out_in;
      ins_ff    <= ins_in;
      // tap pipeline: address and xy weight, read and xyz weight, products
      a_ff    <= lin[AW-1:0];
      wxyr_ff <= wxy_raw;
      wz_ff   <= ent_ff.w[2][t_ff[5:4]];
      qlp_ff  <= 51'(wxy) * 51'(wz_ff);
      px_ff   <= $signed({1'b0, ql}) * $signed(rd_ff[31:0]);
      py_ff   <= $signed({1'b0, ql}) * $signed(rd_ff[63:32]);
      pz_ff   <= $signed({1'b0, ql}) * $signed(rd_ff[95:64]);
   end

endmodule

// ===== hw/rtl/cubic_bspline_point_warp_core.sv =====
// top level of the cubic b-spline point warp
//
//  channel  ports                              direction  content
//  req      req_tvalid/tready/tdata/tuser      in         coefficient write or point
//  rsp      rsp_tvalid/tready/tdata/tuser      out        warped point, inside flag
//  csr      csr_valid/ready/index/data         in         origin and reciprocal spacing
//
//  a coefficient write skips the per-axis arithmetic; a point is worked in the front end
//  one axis at a time through one shared datapath, and in the back end with one
//  coefficient memory read per neighbour for 64 neighbours
//  after reset a clearing pass zeroes the 4096-entry memory, req stalls
//  a two-entry queue lets the front end work on the next request while the back end
//  sums; a stalled response holds the back end, and the front end once the queue fills
module cubic_bspline_point_warp_core #(
   parameter int REGIONS_X = cbpw_pkg::DEF_REGIONS,
   parameter int REGIONS_Y = cbpw_pkg::DEF_REGIONS,
   parameter int REGIONS_Z = cbpw_pkg::DEF_REGIONS,
   parameter int VPR_X     = cbpw_pkg::DEF_VPR,
   parameter int VPR_Y     = cbpw_pkg::DEF_VPR,
   parameter int VPR_Z     = cbpw_pkg::DEF_VPR
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // coef_index, coef_dx, coef_dy, coef_dz, point_x, point_y, point_z, zero fill
   input  logic [207:0] req_tdata,
   // opcode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // warped_x, warped_y, warped_z
   output logic [95:0]  rsp_tdata,
   // inside_res
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import cbpw_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   qstat_type q_stat;
   bstat_type b_stat;
   qent_type  push_ent, head;
   logic      push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORG_X: cfg_in.org[0] = csr_data;
            CSR_ORG_Y: cfg_in.org[1] = csr_data;
            CSR_ORG_Z: cfg_in.org[2] = csr_data;
            CSR_INV_X: cfg_in.inv[0] = csr_data;
            CSR_INV_Y: cfg_in.inv[1] = csr_data;
            CSR_INV_Z: cfg_in.inv[2] = csr_data;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.org <= '0;
         cfg_ff.inv <= {3{32'd16777216}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbpw_front #(
      .REGIONS_X(REGIONS_X), .REGIONS_Y(REGIONS_Y), .REGIONS_Z(REGIONS_Z),
      .VPR_X(VPR_X), .VPR_Y(VPR_Y), .VPR_Z(VPR_Z)
   ) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .enable(b_stat.clear_done),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .q_stat(q_stat), .push(push), .push_ent(push_ent)
   );

   cbpw_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_ent(push_ent),
      .pop(pop), .head(head), .stat(q_stat)
   );

   cbpw_back #(
      .REGIONS_X(REGIONS_X), .REGIONS_Y(REGIONS_Y)
   ) u_back (
      .clock(clock), .reset(reset), .head(head), .q_stat(q_stat), .pop(pop),
      .stat(b_stat), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full) else $error("queue push while full");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("queue pop while empty");

   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      !b_stat.clear_done |-> !(req_tvalid && req_tready))
      else $error("request taken during memory clear");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      !b_stat.clear_done |-> !rsp_tvalid) else $error("response during memory clear");

endmodule

// ===== dv/tb_cubic_bspline_point_warp_core.sv =====
// self-checking testbench for the cubic b-spline point warp core
`timescale 1ns / 100ps

class warp_scoreboard;
   logic signed [31:0] org [3];
   logic [31:0] inv [3];
   logic signed [31:0] store [3][4096];
   logic [96:0] pending [$];
   int errors;
   int shown;

   function void clear();
      for (int d = 0; d < 3; d++) begin
         org[d] = 0;
         inv[d] = 32'h0100_0000;
         for (int i = 0; i < 4096; i++) store[d][i] = 0;
      end
      errors = 0;
      shown = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [31:0] val);
      if (idx < 3) org[idx] = val;
      else if (idx < 6) inv[idx - 3] = val;
   endfunction

   function logic [63:0] six_to_w(logic [63:0] s);
      return (s + (64'd3 << 24)) / (64'd6 << 24);
   endfunction

   function void note_request(logic op, logic [207:0] data);
      logic [63:0] w [3][4];
      longint p [3];
      longint acc [3];
      logic signed [31:0] pt [3];
      logic [31:0] res [3];
      bit ins;
      longint diff, v, tl, r, lin, sum;
      logic [63:0] mag, prod, q, u, t2, t3, wxy, ql;
      int vpr;
      ins = 1;
      if (op == cbpw_pkg::OP_WRITE) begin
         for (int d = 0; d < 3; d++) store[d][data[11:0]] = data[12 + 32*d +: 32];
         return;
      end
      vpr = 8;
      for (int d = 0; d < 3; d++) begin
         pt[d] = data[108 + 32*d +: 32];
         acc[d] = 0;
      end
      for (int d = 0; d < 3 && ins; d++) begin
         diff = longint'(pt[d]) - longint'(org[d]);
         mag = diff < 0 ? -diff : diff;
         prod = mag * {32'd0, inv[d]};
         v = diff < 0 ? -longint'((prod + 64'hFFFFFF) >> 24) : longint'(prod >> 24);
         tl = vpr * 65536;
         if (v < 0) ins = 0;
         else begin
            p[d] = v / tl;
            if (p[d] >= 13) ins = 0;
            else begin
               r = v - p[d] * tl;
               q = r / vpr;
               u = 65536 - q;
               t2 = q * q;
               t3 = t2 * q;
               w[d][0] = six_to_w(u * u * u);
               w[d][1] = six_to_w(3 * t3 + (64'd4 << 48) - ((6 * t2) << 16));
               w[d][2] = six_to_w(((3 * t2) << 16) + ((3 * q) << 32) + (64'd1 << 48) - 3 * t3);
               w[d][3] = six_to_w(t3);
            end
         end
      end
      if (ins) begin
         for (int k = 0; k < 4; k++)
            for (int j = 0; j < 4; j++)
               for (int i = 0; i < 4; i++) begin
                  wxy = (w[0][i] * w[1][j] + (64'd1 << 23)) >> 24;
                  ql = (wxy * w[2][k] + (64'd1 << 23)) >> 24;
                  lin = (p[2] + k) * 256 + (p[1] + j) * 16 + (p[0] + i);
                  for (int d = 0; d < 3; d++)
                     acc[d] += longint'(ql) * longint'(store[d][lin[11:0]]);
               end
      end
      for (int d = 0; d < 3; d++) begin
         sum = pt[d];
         if (ins) begin
            sum += (acc[d] + (64'sd1 <<< 23)) >>> 24;
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
         end
         res[d] = sum[31:0];
      end
      pending.push_back({ins, res[2], res[1], res[0]});
   endfunction

   function void check_result(logic [95:0] data, logic flag);
      logic [96:0] exp_item;
      if (pending.size() == 0) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("unexpected response %h inside %b", data, flag);
         end
         return;
      end
      exp_item = pending.pop_front();
      if (exp_item !== {flag, data}) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("mismatch: expected %h inside %b, got %h inside %b",
                     exp_item[95:0], exp_item[96], data, flag);
         end
      end
   endfunction
endclass

module tb_cubic_bspline_point_warp_core;
   import cbpw_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [207:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   warp_scoreboard warp_sb;
   int quiet_cycles = 0;
   bit stim_done = 0;

   cubic_bspline_point_warp_core uut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
                     || (csr_valid && csr_ready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side: random back-pressure, checked at the edge
   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         warp_sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      warp_sb.set_reg(idx, val);
   endtask

   task automatic send_request(logic op, logic [207:0] data, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      warp_sb.note_request(op, data);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (warp_sb.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [207:0] pack_write(logic [11:0] idx, logic [31:0] a,
                                               logic [31:0] b, logic [31:0] c);
      return {100'd0, c, b, a, idx};
   endfunction

   function automatic logic [207:0] pack_point(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z);
      return {4'd0, z, y, x, $urandom(), $urandom(), $urandom(), 12'($urandom())};
   endfunction

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000 | 32'($urandom_range(0, 3));
         2: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
         default: return 32'($urandom_range(0, 32'h0067_FFFF));
      endcase
   endfunction

   function automatic logic [31:0] rnd_coef();
      case ($urandom_range(0, 3))
         0: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   initial begin
      int phase_ok;
      bit burst;
      warp_sb = new();
      warp_sb.clear();
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed requests
      send_request(OP_XFORM, pack_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
      send_request(OP_WRITE, pack_write(12'h000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000));
      send_request(OP_WRITE, pack_write(12'h111, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000));
      send_request(OP_WRITE, pack_write(12'hFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678));
      send_request(OP_XFORM, pack_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
      send_request(OP_XFORM, pack_point(32'h0008_8000, 32'h0008_0000, 32'h0007_FFFF));
      send_request(OP_XFORM, pack_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000));
      send_request(OP_XFORM, pack_point(32'h0068_0000, 32'h0000_0000, 32'h0000_0000));
      send_request(OP_XFORM, pack_point(32'h0067_FFFF, 32'h0067_FFFF, 32'h0067_FFFF));
      send_request(OP_XFORM, pack_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
      send_request(OP_XFORM, pack_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         for (int r = 0; r < 6; r++) begin
            logic [31:0] val;
            if (r < 3)
               case (ph)
                  0: val = 0;
                  1: val = 32'h8000_0000;
                  2: val = 32'h7FFF_FFFF;
                  default: val = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
               endcase
            else
               case (ph)
                  0: val = 32'h0100_0000;
                  1: val = 32'hFFFF_FFFF;
                  2: val = 32'd1;
                  default: val = $urandom_range(32'h0040_0000, 32'h0200_0000);
               endcase
            write_csr(r[2:0], val);
         end
         write_csr(3'd6 + 3'($urandom_range(0, 1)), $urandom());
         csr_valid <= 0;
         phase_ok = (ph < 3) ? 60 : 590;
         burst = 0;
         for (int n = 0; n < phase_ok; n++) begin
            if (n % 40 == 0) burst = $urandom_range(0, 2) == 0;
            if ($urandom_range(0, 2) == 0)
               send_request(OP_WRITE, pack_write($urandom(), rnd_coef(), rnd_coef(),
                                                 rnd_coef()), burst);
            else
               send_request(OP_XFORM, pack_point(rnd_coord(), rnd_coord(), rnd_coord()),
                            burst);
         end
         drain();
      end

      if (warp_sb.errors == 0 && warp_sb.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
